// ===== hdl/aaf_pkg.sv =====
// shared types, operation codes and flag helpers for the accumulator alu
package aaf_pkg;

    typedef enum logic [4:0] {
        OP_ADD       = 5'd0,
        OP_ADC       = 5'd1,
        OP_SUB       = 5'd2,
        OP_SBB       = 5'd3,
        OP_ANA       = 5'd4,
        OP_XRA       = 5'd5,
        OP_ORA       = 5'd6,
        OP_CMP       = 5'd7,
        OP_INR       = 5'd8,
        OP_DCR       = 5'd9,
        OP_RLC       = 5'd10,
        OP_RRC       = 5'd11,
        OP_RAL       = 5'd12,
        OP_RAR       = 5'd13,
        OP_DAA       = 5'd14,
        OP_CMA       = 5'd15,
        OP_STC       = 5'd16,
        OP_CMC       = 5'd17,
        OP_LOAD_A    = 5'd18,
        OP_LOAD_FLAG = 5'd19
    } op_t;

    typedef struct packed {
        logic s;
        logic z;
        logic ac;
        logic p;
        logic c;
    } flags_t;

    localparam flags_t FLAGS_CLEAR = '0;

    localparam logic [3:0] DAA_LOW_LIMIT  = 4'd9;
    localparam logic [7:0] DAA_HIGH_LIMIT = 8'h99;
    localparam logic [7:0] DAA_LOW_CORR   = 8'h06;
    localparam logic [7:0] DAA_HIGH_CORR  = 8'h60;

    // replace sign, zero and even parity from a byte
    function automatic flags_t set_szp(flags_t f, logic [7:0] r);
        flags_t o;
        o   = f;
        o.s = r[7];
        o.z = (r == 8'h00);
        o.p = ~^r;
        return o;
    endfunction

    // flag byte layout: s7 z6 ac4 p2 c0, bit 1 always set
    function automatic logic [7:0] pack_flags(flags_t f);
        return {f.s, f.z, 1'b0, f.ac, 1'b0, f.p, 1'b1, f.c};
    endfunction

    function automatic flags_t unpack_flags(logic [7:0] b);
        flags_t o;
        o.s  = b[7];
        o.z  = b[6];
        o.ac = b[4];
        o.p  = b[2];
        o.c  = b[0];
        return o;
    endfunction

endpackage

// ===== hdl/aaf_alu.sv =====
// combinational 8-bit alu: new accumulator, flags and result for one operation
module aaf_alu (
    input  logic [4:0]     op,
    input  logic [7:0]     operand,
    input  logic [7:0]     acc,
    input  aaf_pkg::flags_t flags,
    output logic [7:0]     result,
    output logic [7:0]     acc_new,
    output aaf_pkg::flags_t flags_new
);

    logic [8:0] sum9;
    logic [8:0] diff9;
    logic       add_cin;
    logic       sub_bin;
    logic [7:0] inc_val;
    logic [7:0] dec_val;
    logic [7:0] daa_corr;
    logic       daa_carry;
    logic [7:0] daa_val;

    // carry-in only for the with-carry forms
    assign add_cin = (aaf_pkg::op_t'(op) == aaf_pkg::OP_ADC) ? flags.c : 1'b0;
    assign sub_bin = (aaf_pkg::op_t'(op) == aaf_pkg::OP_SBB) ? flags.c : 1'b0;

    assign sum9  = {1'b0, acc} + {1'b0, operand} + {8'h00, add_cin};
    assign diff9 = {1'b0, acc} - {1'b0, operand} - {8'h00, sub_bin};

    assign inc_val = operand + 8'd1;
    assign dec_val = operand - 8'd1;

    assign daa_carry = flags.c || (acc > aaf_pkg::DAA_HIGH_LIMIT);
    assign daa_corr  = ((flags.ac || (acc[3:0] > aaf_pkg::DAA_LOW_LIMIT))
                        ? aaf_pkg::DAA_LOW_CORR : 8'h00)
                     | (daa_carry ? aaf_pkg::DAA_HIGH_CORR : 8'h00);
    assign daa_val   = acc + daa_corr;

    always_comb begin
        acc_new   = acc;
        flags_new = flags;
        result    = acc;
        case (aaf_pkg::op_t'(op))
            aaf_pkg::OP_ADD, aaf_pkg::OP_ADC: begin
                acc_new      = sum9[7:0];
                flags_new    = aaf_pkg::set_szp(flags, sum9[7:0]);
                flags_new.c  = sum9[8];
                flags_new.ac = acc[4] ^ operand[4] ^ sum9[4];
            end
            aaf_pkg::OP_SUB, aaf_pkg::OP_SBB, aaf_pkg::OP_CMP: begin
                if (aaf_pkg::op_t'(op) != aaf_pkg::OP_CMP) begin
                    acc_new = diff9[7:0];
                end
                flags_new    = aaf_pkg::set_szp(flags, diff9[7:0]);
                flags_new.c  = diff9[8];
                flags_new.ac = acc[4] ^ operand[4] ^ diff9[4];
            end
            aaf_pkg::OP_ANA: begin
                acc_new      = acc & operand;
                flags_new    = aaf_pkg::set_szp(flags, acc & operand);
                flags_new.ac = 1'b1;
                flags_new.c  = 1'b0;
            end
            aaf_pkg::OP_XRA: begin
                acc_new      = acc ^ operand;
                flags_new    = aaf_pkg::set_szp(flags, acc ^ operand);
                flags_new.ac = 1'b0;
                flags_new.c  = 1'b0;
            end
            aaf_pkg::OP_ORA: begin
                acc_new      = acc | operand;
                flags_new    = aaf_pkg::set_szp(flags, acc | operand);
                flags_new.ac = 1'b0;
                flags_new.c  = 1'b0;
            end
            aaf_pkg::OP_INR: begin
                flags_new    = aaf_pkg::set_szp(flags, inc_val);
                flags_new.ac = operand[4] ^ inc_val[4];
            end
            aaf_pkg::OP_DCR: begin
                flags_new    = aaf_pkg::set_szp(flags, dec_val);
                flags_new.ac = operand[4] ^ dec_val[4];
            end
            aaf_pkg::OP_RLC: begin
                acc_new     = {acc[6:0], acc[7]};
                flags_new.c = acc[7];
            end
            aaf_pkg::OP_RRC: begin
                acc_new     = {acc[0], acc[7:1]};
                flags_new.c = acc[0];
            end
            aaf_pkg::OP_RAL: begin
                acc_new     = {acc[6:0], flags.c};
                flags_new.c = acc[7];
            end
            aaf_pkg::OP_RAR: begin
                acc_new     = {flags.c, acc[7:1]};
                flags_new.c = acc[0];
            end
            aaf_pkg::OP_DAA: begin
                acc_new      = daa_val;
                flags_new    = aaf_pkg::set_szp(flags, daa_val);
                flags_new.c  = daa_carry;
                flags_new.ac = acc[4] ^ daa_val[4];
            end
            aaf_pkg::OP_CMA:       acc_new     = ~acc;
            aaf_pkg::OP_STC:       flags_new.c = 1'b1;
            aaf_pkg::OP_CMC:       flags_new.c = ~flags.c;
            aaf_pkg::OP_LOAD_A:    acc_new     = operand;
            aaf_pkg::OP_LOAD_FLAG: flags_new   = aaf_pkg::unpack_flags(operand);
            default: begin
                acc_new   = acc;
                flags_new = flags;
            end
        endcase

        // inr and dcr report their own value, everything else the accumulator
        case (aaf_pkg::op_t'(op))
            aaf_pkg::OP_INR: result = inc_val;
            aaf_pkg::OP_DCR: result = dec_val;
            default:         result = acc_new;
        endcase
    end

endmodule

// ===== hdl/accumulator_alu_with_flags.sv =====
// top level of the accumulator alu: input register, alu, result register and state
//
// usage
//   slave channel s_*: one transaction carries an operation code and an operand byte
//   master channel m_*: one transaction per input, carrying the result byte, the
//     accumulator after the operation and the packed flag byte (s7 z6 ac4 p2 c0,
//     bit 1 always set)
//   path: an accepted transaction is captured in the input register, passes the
//     alu and is registered in the result register, from which it is offered on m_*
//   throughput: one transaction per cycle while not stalled, set by the single alu
//     pass between the input and result registers; the accumulator and flag registers
//     are updated in that same cycle so back-to-back operations see each other
//   reset: aresetn low at a clock edge empties both registers, clears the
//     accumulator and all flags (the flag byte then reads 0x02)
//   stall: while m_tready is low the result register holds; the input register
//     still takes one more transaction, after which s_tready drops until the
//     result is taken
module accumulator_alu_with_flags (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [4:0] op, [12:5] operand, [15:13] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] result, [15:8] acc_out, [23:16] flag_byte
);

    // input register
    logic            in_valid_reg, in_valid_next;
    logic [4:0]      in_op_reg;
    logic [7:0]      in_operand_reg;

    // architectural state
    logic [7:0]      acc_reg, acc_next;
    aaf_pkg::flags_t flags_reg, flags_next;

    // result register
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_result_reg;
    logic [7:0]      out_acc_reg;
    logic [7:0]      out_flag_byte_reg;

    // alu outputs
    logic [7:0]      alu_result;
    logic [7:0]      alu_acc;
    aaf_pkg::flags_t alu_flags;

    logic            s_fire;
    logic            advance;   // result register free to take the next alu output

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    aaf_alu u_alu (
        .op        (in_op_reg),
        .operand   (in_operand_reg),
        .acc       (acc_reg),
        .flags     (flags_reg),
        .result    (alu_result),
        .acc_new   (alu_acc),
        .flags_new (alu_flags)
    );

    always_comb begin
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        out_valid_next = advance ? in_valid_reg : out_valid_reg;

        // state moves only when the item leaves the alu
        if (advance && in_valid_reg) begin
            acc_next   = alu_acc;
            flags_next = alu_flags;
        end else begin
            acc_next   = acc_reg;
            flags_next = flags_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= 8'h00;
            flags_reg     <= aaf_pkg::FLAGS_CLEAR;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            acc_reg       <= acc_next;
            flags_reg     <= flags_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg      <= s_tdata[4:0];
            in_operand_reg <= s_tdata[12:5];
        end
        if (advance && in_valid_reg) begin
            out_result_reg    <= alu_result;
            out_acc_reg       <= alu_acc;
            out_flag_byte_reg <= aaf_pkg::pack_flags(alu_flags);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_flag_byte_reg, out_acc_reg, out_result_reg};

    // the offered transaction always shows the current architectural accumulator
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_acc_reg == acc_reg))
        else $error("offered accumulator differs from accumulator register");

    // and the current flags in packed form
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_flag_byte_reg == aaf_pkg::pack_flags(flags_reg)))
        else $error("offered flag byte differs from flag register");

    // an item waiting in the input register is not lost while the output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_op_reg)
                                        && $stable(in_operand_reg)))
        else $error("stalled input register changed");

    // state changes only when an item passes into the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(advance && in_valid_reg) |=> ($stable(acc_reg) && $stable(flags_reg)))
        else $error("state changed without a transaction");

endmodule

// ===== verif/accumulator_alu_with_flags_test.sv =====
// self-checking testbench for the accumulator alu: directed table, then random traffic
module accumulator_alu_with_flags_test;

    timeunit 1ns;
    timeprecision 1ps;

    // codes outside the defined set, the block must leave its state alone
    localparam logic [4:0] OP_UNUSED_LO = 5'd20;
    localparam logic [4:0] OP_UNUSED_HI = 5'd31;

    localparam int RANDOM_ITEMS = 625;
    localparam int CALM_ITEMS   = 100;   // closing stretch with no idling
    localparam int MAX_REPORTS  = 10;

    // one result transaction, laid out as m_tdata
    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] acc;
        logic [7:0] res;
    } alu_out_t;

    typedef struct packed {
        logic [4:0] code;
        logic [7:0] v;
        logic       typed;   // want holds a hand-worked result
        alu_out_t   want;
    } stim_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [4:0] op, [12:5] operand, [15:13] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] result, [15:8] acc_out, [23:16] flag_byte

    // model state of the alu
    logic [7:0]      acc_now;
    aaf_pkg::flags_t flags_now;

    alu_out_t   alu_results_q[$];
    int         mismatch_count;
    bit         idle_off;
    int         gap_odds;

    localparam int DIR_ROWS = 27;
    stim_row_t dir_tab [DIR_ROWS] = '{
        // state just after reset
        '{aaf_pkg::OP_LOAD_FLAG, 8'h00, 1'b1, '{8'h02, 8'h00, 8'h00}},
        '{aaf_pkg::OP_ADD,       8'h00, 1'b1, '{8'h46, 8'h00, 8'h00}},
        '{aaf_pkg::OP_LOAD_A,    8'hFF, 1'b1, '{8'h46, 8'hFF, 8'hFF}},
        // carry out of bit 7 with wrap to zero
        '{aaf_pkg::OP_ADD,       8'h01, 1'b1, '{8'h57, 8'h00, 8'h00}},
        '{aaf_pkg::OP_ADC,       8'hFF, 1'b0, '0},
        // borrow from zero
        '{aaf_pkg::OP_SUB,       8'h01, 1'b1, '{8'h97, 8'hFF, 8'hFF}},
        '{aaf_pkg::OP_SBB,       8'hFF, 1'b0, '0},
        '{aaf_pkg::OP_LOAD_A,    8'h80, 1'b0, '0},
        // and sets auxiliary carry even on a zero result
        '{aaf_pkg::OP_ANA,       8'h0F, 1'b1, '{8'h56, 8'h00, 8'h00}},
        '{aaf_pkg::OP_LOAD_A,    8'h5A, 1'b0, '0},
        '{aaf_pkg::OP_XRA,       8'hFF, 1'b0, '0},
        '{aaf_pkg::OP_ORA,       8'h00, 1'b0, '0},
        '{aaf_pkg::OP_CMP,       8'hFF, 1'b0, '0},
        '{aaf_pkg::OP_INR,       8'hFF, 1'b0, '0},
        '{aaf_pkg::OP_DCR,       8'h00, 1'b0, '0},
        '{aaf_pkg::OP_RLC,       8'h00, 1'b0, '0},
        '{aaf_pkg::OP_RRC,       8'hFF, 1'b0, '0},
        '{aaf_pkg::OP_RAL,       8'h00, 1'b0, '0},
        '{aaf_pkg::OP_RAR,       8'h00, 1'b0, '0},
        '{aaf_pkg::OP_LOAD_A,    8'h9B, 1'b0, '0},
        '{aaf_pkg::OP_DAA,       8'h00, 1'b0, '0},
        '{aaf_pkg::OP_CMA,       8'h00, 1'b0, '0},
        '{aaf_pkg::OP_STC,       8'h00, 1'b0, '0},
        '{aaf_pkg::OP_CMC,       8'h00, 1'b0, '0},
        // flag load keeps only the five flag bits
        '{aaf_pkg::OP_LOAD_FLAG, 8'hFF, 1'b0, '0},
        '{OP_UNUSED_HI,          8'hFF, 1'b0, '0},
        '{OP_UNUSED_LO,          8'h00, 1'b0, '0}
    };

    accumulator_alu_with_flags DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // sign, zero and even parity of r, with carry and auxiliary carry given
    function automatic aaf_pkg::flags_t flags_from(logic c, logic ac, logic [7:0] r);
        aaf_pkg::flags_t f;
        f.c  = c;
        f.ac = ac;
        f.s  = r[7];
        f.z  = (r == 8'h00);
        f.p  = ~^r;
        return f;
    endfunction

    function automatic logic [7:0] flag_byte_of(aaf_pkg::flags_t f);
        return {f.s, f.z, 1'b0, f.ac, 1'b0, f.p, 1'b1, f.c};
    endfunction

    // runs one operation on the model state and returns the result transaction
    function automatic alu_out_t step_alu(logic [4:0] code, logic [7:0] v);
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] corr;
        logic [8:0] wide;
        logic       carry_in;
        logic       daa_c;
        logic       own_res;
        logic [7:0] incdec;
        alu_out_t   o;
        a        = acc_now;
        carry_in = flags_now.c;
        own_res  = 1'b0;
        incdec   = 8'h00;
        case (code)
            aaf_pkg::OP_ADD, aaf_pkg::OP_ADC: begin
                wide = {1'b0, a} + {1'b0, v}
                     + {8'h00, (code == aaf_pkg::OP_ADC) ? carry_in : 1'b0};
                r = wide[7:0];
                flags_now = flags_from(wide[8], a[4] ^ v[4] ^ r[4], r);
                acc_now = r;
            end
            aaf_pkg::OP_SUB, aaf_pkg::OP_SBB, aaf_pkg::OP_CMP: begin
                // borrow shows as the ninth bit of the difference
                wide = {1'b0, a} - {1'b0, v}
                     - {8'h00, (code == aaf_pkg::OP_SBB) ? carry_in : 1'b0};
                r = wide[7:0];
                flags_now = flags_from(wide[8], a[4] ^ v[4] ^ r[4], r);
                if (code != aaf_pkg::OP_CMP) begin
                    acc_now = r;
                end
            end
            aaf_pkg::OP_ANA: begin
                acc_now   = a & v;
                flags_now = flags_from(1'b0, 1'b1, a & v);
            end
            aaf_pkg::OP_XRA: begin
                acc_now   = a ^ v;
                flags_now = flags_from(1'b0, 1'b0, a ^ v);
            end
            aaf_pkg::OP_ORA: begin
                acc_now   = a | v;
                flags_now = flags_from(1'b0, 1'b0, a | v);
            end
            aaf_pkg::OP_INR, aaf_pkg::OP_DCR: begin
                // works on the operand, accumulator and carry untouched
                incdec    = (code == aaf_pkg::OP_INR) ? v + 8'h01 : v - 8'h01;
                flags_now = flags_from(carry_in, v[4] ^ incdec[4], incdec);
                own_res   = 1'b1;
            end
            aaf_pkg::OP_RLC: begin
                acc_now     = {a[6:0], a[7]};
                flags_now.c = a[7];
            end
            aaf_pkg::OP_RRC: begin
                acc_now     = {a[0], a[7:1]};
                flags_now.c = a[0];
            end
            aaf_pkg::OP_RAL: begin
                acc_now     = {a[6:0], carry_in};
                flags_now.c = a[7];
            end
            aaf_pkg::OP_RAR: begin
                acc_now     = {carry_in, a[7:1]};
                flags_now.c = a[0];
            end
            aaf_pkg::OP_DAA: begin
                corr  = 8'h00;
                daa_c = carry_in;
                if (flags_now.ac || a[3:0] > 4'd9) begin
                    corr = corr | 8'h06;
                end
                if (daa_c || a > 8'h99) begin
                    corr  = corr | 8'h60;
                    daa_c = 1'b1;
                end
                r         = a + corr;
                flags_now = flags_from(daa_c, a[4] ^ r[4], r);
                acc_now   = r;
            end
            aaf_pkg::OP_CMA:    acc_now = ~a;
            aaf_pkg::OP_STC:    flags_now.c = 1'b1;
            aaf_pkg::OP_CMC:    flags_now.c = ~flags_now.c;
            aaf_pkg::OP_LOAD_A: acc_now = v;
            aaf_pkg::OP_LOAD_FLAG: begin
                flags_now.s  = v[7];
                flags_now.z  = v[6];
                flags_now.ac = v[4];
                flags_now.p  = v[2];
                flags_now.c  = v[0];
            end
            default: ;
        endcase
        o.res       = own_res ? incdec : acc_now;
        o.acc       = acc_now;
        o.flag_byte = flag_byte_of(flags_now);
        return o;
    endfunction

    // offers one transaction, optionally after an idle burst, and waits for acceptance
    task automatic drive_op(input logic [4:0] code, input logic [7:0] v,
                            input logic typed, input alu_out_t want);
        alu_out_t model;
        if (!idle_off && $urandom_range(0, 3) < gap_odds) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, v, code};
        model = step_alu(code, v);
        alu_results_q.push_back(typed ? want : model);
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [7:0] pick_operand();
        logic [7:0] corners [6] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h99, 8'h0F};
        if ($urandom_range(0, 4) == 0) begin
            return corners[$urandom_range(0, 5)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_bcd();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    // stimulus
    initial begin
        int         sent;
        logic [4:0] code;
        logic [4:0] arith [4];
        arith          = '{aaf_pkg::OP_ADD, aaf_pkg::OP_ADC, aaf_pkg::OP_SUB, aaf_pkg::OP_SBB};
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        acc_now        = 8'h00;
        flags_now      = aaf_pkg::FLAGS_CLEAR;
        mismatch_count = 0;
        idle_off       = 1'b0;
        gap_odds       = 1;
        sent           = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            drive_op(dir_tab[i].code, dir_tab[i].v, dir_tab[i].typed, dir_tab[i].want);
        end

        while (sent < RANDOM_ITEMS) begin
            if (sent % 64 == 0) begin
                gap_odds = $urandom_range(0, 3);
            end
            if (sent >= RANDOM_ITEMS - CALM_ITEMS) begin
                idle_off = 1'b1;
            end
            if ($urandom_range(0, 3) == 0) begin
                // decimal sequence: load a bcd value, add or subtract bcd, adjust
                drive_op(aaf_pkg::OP_LOAD_A, pick_bcd(), 1'b0, '0);
                drive_op(arith[$urandom_range(0, 3)], pick_bcd(), 1'b0, '0);
                drive_op(aaf_pkg::OP_DAA, pick_operand(), 1'b0, '0);
                sent += 3;
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    code = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
                end else begin
                    code = 5'($urandom_range(aaf_pkg::OP_ADD, aaf_pkg::OP_LOAD_FLAG));
                end
                drive_op(code, pick_operand(), 1'b0, '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (alu_results_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // result side backpressure: stall bursts between runs of readiness, always ready once idling is off
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (idle_off) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge aclk);
            end
        end
    end

    // checks every accepted result transaction against the oldest prediction
    always @(posedge aclk) begin
        alu_out_t got;
        alu_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (alu_results_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result transaction %h", got);
                end
            end else begin
                want = alu_results_q.pop_front();
                if (got.res !== want.res || got.acc !== want.acc
                        || got.flag_byte !== want.flag_byte) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: result %h/%h acc %h/%h flags %h/%h (expected/actual)",
                                 want.res, got.res, want.acc, got.acc,
                                 want.flag_byte, got.flag_byte);
                    end
                end
            end
        end
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
